>>> src/segi_pkg.sv
// segi_pkg: shared constants for the segment intersection block
// no dependencies; used by segi_div and segment_intersection_top
`default_nettype none
package segi_pkg;
  localparam int OUT_BITS = 32;
  localparam int MIN_QUOT_BITS = 8;
endpackage
`default_nettype wire

>>> src/segi_div.sv
// segi_div: pipelined restoring divider, one quotient bit per register stage
// depends on segi_pkg for the minimum quotient width
`default_nettype none
module segi_div #(
  parameter int DIV_BITS  = 33,
  parameter int LOW_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [DIV_BITS+LOW_BITS-1:0]      dividend,
  input  wire logic [DIV_BITS-1:0]               divisor,
  output logic      [LOW_BITS+FRAC_BITS-1:0]     quot
);
  localparam int QB = LOW_BITS + FRAC_BITS;

  logic [DIV_BITS-1:0] rem      [1:QB-1];
  logic [DIV_BITS-1:0] dv       [1:QB-1];
  logic [QB-1:0]       z        [1:QB];
  logic [DIV_BITS-1:0] rem_in   [0:QB-1];
  logic [DIV_BITS-1:0] dv_in    [0:QB-1];
  logic [QB-1:0]       z_in     [0:QB-1];
  logic [DIV_BITS-1:0] rem_next [0:QB-1];
  logic [QB-1:0]       z_next   [0:QB-1];

  always_comb begin
    rem_in[0] = dividend[DIV_BITS+LOW_BITS-1:LOW_BITS];
    dv_in[0]  = divisor;
    z_in[0]   = QB'(dividend[LOW_BITS-1:0]) << FRAC_BITS;
    for (int k = 1; k < QB; k++) begin
      rem_in[k] = rem[k];
      dv_in[k]  = dv[k];
      z_in[k]   = z[k];
    end
  end

  // each step shifts one dividend bit into the remainder
  always_comb begin
    logic [DIV_BITS:0] tmp;
    logic              ge;
    for (int k = 0; k < QB; k++) begin
      tmp = {rem_in[k], z_in[k][QB-1]};
      ge  = tmp >= {1'b0, dv_in[k]};
      rem_next[k] = ge ? DIV_BITS'(tmp - {1'b0, dv_in[k]}) : tmp[DIV_BITS-1:0];
      z_next[k]   = {z_in[k][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB - 1; k++) begin
        rem[k+1] <= rem_next[k];
        dv[k+1]  <= dv_in[k];
      end
      for (int k = 0; k < QB; k++) begin
        z[k+1] <= z_next[k];
      end
    end
  end

  assign quot = z[QB];

  always_ff @(posedge clk) begin
    if (QB < segi_pkg::MIN_QUOT_BITS) $error("quotient too narrow");
  end
endmodule
`default_nettype wire

>>> src/segment_intersection_top.sv
// segment_intersection_top: pipelined 2d segment intersection in fixed point
// depends on segi_pkg and segi_div
// usage:
//   the source channel (src_valid, src_stall) carries one beat per segment pair,
//   eight signed COORD_BITS coordinates. the result channel (res_valid,
//   res_stall) returns one beat per pair: hit and the point in signed
//   fixed point with FRAC_BITS fraction bits, zero when there is no hit.
//   while no result is held by res_stall, a new pair can be taken every cycle
//   and throughput is one beat per cycle. the pipeline has five stages for
//   differences, products, cross terms, range test and scaling, one stage
//   per quotient bit in the divider, and the output register.
//   the whole pipeline advances together; while a result is held by
//   res_stall, src_stall is raised and every stage keeps its beat.
//   bubbles ahead of a stalled result are not squeezed out.
//   reset clears all valid bits; the datapath needs no reset.
`default_nettype none
module segment_intersection_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         src_valid,
  output logic                              src_stall,
  input  wire logic signed [COORD_BITS-1:0] a_start_x,
  input  wire logic signed [COORD_BITS-1:0] a_start_y,
  input  wire logic signed [COORD_BITS-1:0] a_end_x,
  input  wire logic signed [COORD_BITS-1:0] a_end_y,
  input  wire logic signed [COORD_BITS-1:0] b_start_x,
  input  wire logic signed [COORD_BITS-1:0] b_start_y,
  input  wire logic signed [COORD_BITS-1:0] b_end_x,
  input  wire logic signed [COORD_BITS-1:0] b_end_y,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output logic                              hit,
  output logic signed [segi_pkg::OUT_BITS-1:0] point_x,
  output logic signed [segi_pkg::OUT_BITS-1:0] point_y
);
  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int WW = 2 * C + 2;
  localparam int DB = 2 * C + 1;
  localparam int MB = C + DB;
  localparam int QB = C + FRAC_BITS;
  localparam int XW = QB + 2;
  localparam int OB = segi_pkg::OUT_BITS;

  logic en;
  assign en        = !(res_valid && res_stall);
  assign src_stall = !en;

  // stage 1: differences
  logic                 s1_valid;
  logic signed [DW-1:0] s1_dax, s1_day, s1_dbx, s1_dby, s1_sx, s1_sy;
  logic signed [C-1:0]  s1_ax, s1_ay;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dax <= $signed({a_end_x[C-1], a_end_x}) - $signed({a_start_x[C-1], a_start_x});
      s1_day <= $signed({a_end_y[C-1], a_end_y}) - $signed({a_start_y[C-1], a_start_y});
      s1_dbx <= $signed({b_end_x[C-1], b_end_x}) - $signed({b_start_x[C-1], b_start_x});
      s1_dby <= $signed({b_end_y[C-1], b_end_y}) - $signed({b_start_y[C-1], b_start_y});
      s1_sx  <= $signed({a_start_x[C-1], a_start_x}) - $signed({b_start_x[C-1], b_start_x});
      s1_sy  <= $signed({a_start_y[C-1], a_start_y}) - $signed({b_start_y[C-1], b_start_y});
      s1_ax  <= a_start_x;
      s1_ay  <= a_start_y;
    end
  end

  // stage 2: cross products
  logic                 s2_valid;
  logic signed [WW-1:0] s2_p0, s2_p1, s2_p2, s2_p3, s2_p4, s2_p5;
  logic signed [DW-1:0] s2_dax, s2_day;
  logic signed [C-1:0]  s2_ax, s2_ay;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p0  <= s1_dby * s1_dax;
      s2_p1  <= s1_dbx * s1_day;
      s2_p2  <= s1_dbx * s1_sy;
      s2_p3  <= s1_dby * s1_sx;
      s2_p4  <= s1_dax * s1_sy;
      s2_p5  <= s1_day * s1_sx;
      s2_dax <= s1_dax;
      s2_day <= s1_day;
      s2_ax  <= s1_ax;
      s2_ay  <= s1_ay;
    end
  end

  // stage 3: denominator and numerators
  logic                 s3_valid;
  logic signed [WW-1:0] s3_den, s3_numa, s3_numb;
  logic signed [DW-1:0] s3_dax, s3_day;
  logic signed [C-1:0]  s3_ax, s3_ay;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_den  <= s2_p0 - s2_p1;
      s3_numa <= s2_p2 - s2_p3;
      s3_numb <= s2_p4 - s2_p5;
      s3_dax  <= s2_dax;
      s3_day  <= s2_day;
      s3_ax   <= s2_ax;
      s3_ay   <= s2_ay;
    end
  end

  // stage 4: range test and magnitudes
  logic                 s4_valid, s4_hit, s4_negx, s4_negy;
  logic [DB-1:0]        s4_mden, s4_mna;
  logic [C-1:0]         s4_mdx, s4_mdy;
  logic signed [C-1:0]  s4_ax, s4_ay;
  logic                 in_a, in_b;
  logic signed [WW-1:0] abs_den, abs_na;
  logic signed [DW-1:0] abs_dx, abs_dy;

  always_comb begin
    if (s3_den > 0) begin
      in_a = s3_numa >= 0 && s3_numa <= s3_den;
      in_b = s3_numb >= 0 && s3_numb <= s3_den;
    end else begin
      in_a = s3_numa <= 0 && s3_numa >= s3_den;
      in_b = s3_numb <= 0 && s3_numb >= s3_den;
    end
    abs_den = s3_den[WW-1]  ? -s3_den  : s3_den;
    abs_na  = s3_numa[WW-1] ? -s3_numa : s3_numa;
    abs_dx  = s3_dax[DW-1]  ? -s3_dax  : s3_dax;
    abs_dy  = s3_day[DW-1]  ? -s3_day  : s3_day;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hit  <= (s3_den != 0) && in_a && in_b;
      s4_mden <= abs_den[DB-1:0];
      s4_mna  <= abs_na[DB-1:0];
      s4_mdx  <= abs_dx[C-1:0];
      s4_mdy  <= abs_dy[C-1:0];
      s4_negx <= s3_dax[DW-1];
      s4_negy <= s3_day[DW-1];
      s4_ax   <= s3_ax;
      s4_ay   <= s3_ay;
    end
  end

  // stage 5: scaled dividends
  logic          s5_valid;
  logic [MB-1:0] s5_px, s5_py;
  logic [DB-1:0] s5_den;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_px  <= MB'(s4_mdx) * MB'(s4_mna);
      s5_py  <= MB'(s4_mdy) * MB'(s4_mna);
      s5_den <= s4_mden;
    end
  end

  // sideband that travels alongside the divider
  logic                sd_valid [0:QB];
  logic                sd_hit   [0:QB];
  logic                sd_negx  [0:QB];
  logic                sd_negy  [0:QB];
  logic signed [C-1:0] sd_ax    [0:QB];
  logic signed [C-1:0] sd_ay    [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_hit[0]  <= s4_hit;
      sd_negx[0] <= s4_negx;
      sd_negy[0] <= s4_negy;
      sd_ax[0]   <= s4_ax;
      sd_ay[0]   <= s4_ay;
      for (int k = 0; k < QB; k++) begin
        sd_hit[k+1]  <= sd_hit[k];
        sd_negx[k+1] <= sd_negx[k];
        sd_negy[k+1] <= sd_negy[k];
        sd_ax[k+1]   <= sd_ax[k];
        sd_ay[k+1]   <= sd_ay[k];
      end
    end
  end

  assign s5_valid = sd_valid[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      for (int k = 0; k <= QB; k++) sd_valid[k] <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      s1_valid    <= src_valid;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      s4_valid    <= s3_valid;
      sd_valid[0] <= s4_valid;
      for (int k = 0; k < QB; k++) sd_valid[k+1] <= sd_valid[k];
      res_valid   <= sd_valid[QB];
    end
  end

  logic [QB-1:0] qx, qy;

  segi_div #(.DIV_BITS(DB), .LOW_BITS(C), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .en(en), .dividend(s5_px), .divisor(s5_den), .quot(qx)
  );

  segi_div #(.DIV_BITS(DB), .LOW_BITS(C), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .en(en), .dividend(s5_py), .divisor(s5_den), .quot(qy)
  );

  // output: start plus signed quotient
  logic signed [XW-1:0] base_x, base_y, qsx, qsy, px, py;

  always_comb begin
    base_x = XW'(sd_ax[QB]) <<< FRAC_BITS;
    base_y = XW'(sd_ay[QB]) <<< FRAC_BITS;
    qsx    = $signed({2'b00, qx});
    qsy    = $signed({2'b00, qy});
    px     = sd_negx[QB] ? base_x - qsx : base_x + qsx;
    py     = sd_negy[QB] ? base_y - qsy : base_y + qsy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit     <= sd_hit[QB];
      point_x <= sd_hit[QB] ? OB'(px) : '0;
      point_y <= sd_hit[QB] ? OB'(py) : '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !hit) |-> (point_x == 0 && point_y == 0))
    else $error("point not zero without hit");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (src_valid && !src_stall) |=> s1_valid)
    else $error("accepted beat lost at stage 1");

  a_ratio: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && s4_hit) |-> (s4_mna <= s4_mden && s4_mden != 0))
    else $error("hit with numerator above denominator");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (s5_valid && !en) |=> (s5_valid && $stable(s5_den)))
    else $error("stage 5 changed while stalled");
endmodule
`default_nettype wire

>>> tb/segment_intersection_top_tb.sv
// segment_intersection_top_tb: self-checking bench for the segment intersection block
// a scoreboard class predicts hit and the 16.16 point per accepted pair
// depends on segi_pkg and segment_intersection_top
`timescale 1ns / 1ps
module segment_intersection_top_tb;
  localparam int CB = 16;
  localparam int FB = 16;
  localparam int OB = segi_pkg::OUT_BITS;
  localparam int NUM_RANDOM = 1500;
  localparam int QUIET_FROM = 1300;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    bit          hit;
    bit [OB-1:0] px;
    bit [OB-1:0] py;
  } point_beat_t;

  class intersect_scoreboard;
    point_beat_t pending_points[$];
    int errors = 0;

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    function automatic bit in_unit(longint num, longint den);
      if (den > 0) return num >= 0 && num <= den;
      return num <= 0 && num >= den;
    endfunction

    function automatic longint unsigned scaled_quotient(longint unsigned m,
        longint unsigned n, longint unsigned d);
      longint unsigned q, r;
      q = 0;
      r = 0;
      for (int i = CB; i >= 0; i--) begin
        q = q << 1;
        r = r << 1;
        if (r >= d) begin r = r - d; q++; end
        if (m[i]) begin
          r = r + n;
          if (r >= d) begin r = r - d; q++; end
        end
      end
      for (int i = 0; i < FB; i++) begin
        q = q << 1;
        r = r << 1;
        if (r >= d) begin r = r - d; q++; end
      end
      return q;
    endfunction

    function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
    endfunction

    function automatic bit [OB-1:0] point_coord(longint start, longint delta,
        longint numa, longint den);
      longint unsigned q;
      longint base;
      q = scaled_quotient(magnitude(delta), magnitude(numa), magnitude(den));
      base = start * (longint'(1) << FB);
      return delta < 0 ? base - longint'(q) : base + longint'(q);
    endfunction

    function automatic point_beat_t predict_crossing(coord_t c[8]);
      point_beat_t e;
      longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      longint dax, day, dbx, dby, sx, sy, den, numa, numb;
      ax0 = c[0]; ay0 = c[1]; ax1 = c[2]; ay1 = c[3];
      bx0 = c[4]; by0 = c[5]; bx1 = c[6]; by1 = c[7];
      dax = ax1 - ax0; day = ay1 - ay0;
      dbx = bx1 - bx0; dby = by1 - by0;
      sx = ax0 - bx0; sy = ay0 - by0;
      den = dby * dax - dbx * day;
      numa = dbx * sy - dby * sx;
      numb = dax * sy - day * sx;
      e.hit = 0;
      e.px = 0;
      e.py = 0;
      if (den != 0 && in_unit(numa, den) && in_unit(numb, den)) begin
        e.hit = 1;
        e.px = point_coord(ax0, dax, numa, den);
        e.py = point_coord(ay0, day, numa, den);
      end
      return e;
    endfunction

    function void note_pair(coord_t c[8]);
      pending_points.push_back(predict_crossing(c));
    endfunction

    task check_result(logic h, logic [OB-1:0] px, logic [OB-1:0] py);
      point_beat_t e;
      if (pending_points.size() == 0) begin
        report_mismatch("result beat with nothing pending");
        return;
      end
      e = pending_points.pop_front();
      if (h !== e.hit)
        report_mismatch($sformatf("hit got %0d want %0d", h, e.hit));
      if (px !== e.px)
        report_mismatch($sformatf("point_x got %h want %h", px, e.px));
      if (py !== e.py)
        report_mismatch($sformatf("point_y got %h want %h", py, e.py));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic src_valid = 0;
  logic res_stall = 0;
  coord_t a_start_x = 0, a_start_y = 0, a_end_x = 0, a_end_y = 0;
  coord_t b_start_x = 0, b_start_y = 0, b_end_x = 0, b_end_y = 0;
  logic src_stall, res_valid, hit;
  logic signed [OB-1:0] point_x, point_y;

  intersect_scoreboard sb = new();
  int pairs_sent = 0;
  bit pressure_done = 0;
  coord_t directed[$][8];

  segment_intersection_top dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall),
    .a_start_x(a_start_x), .a_start_y(a_start_y),
    .a_end_x(a_end_x), .a_end_y(a_end_y),
    .b_start_x(b_start_x), .b_start_y(b_start_y),
    .b_end_x(b_end_x), .b_end_y(b_end_y),
    .res_valid(res_valid), .res_stall(res_stall),
    .hit(hit), .point_x(point_x), .point_y(point_y)
  );

  always #4 clk = ~clk;

  task send_pair(coord_t c[8]);
    if (pairs_sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
      src_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    a_start_x <= c[0]; a_start_y <= c[1]; a_end_x <= c[2]; a_end_y <= c[3];
    b_start_x <= c[4]; b_start_y <= c[5]; b_end_x <= c[6]; b_end_y <= c[7];
    src_valid <= 1;
    do @(posedge clk); while (src_stall);
    sb.note_pair(c);
    pairs_sent++;
  endtask

  function automatic coord_t pick_coord(int span);
    if (span == 0) return coord_t'($urandom());
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic void random_pair(ref coord_t c[8]);
    int span, k;
    k = $urandom_range(0, 19);
    case ($urandom_range(0, 4))
      0: span = 0;
      1: span = 4;
      2: span = 40;
      3: span = 3000;
      default: span = 32767;
    endcase
    if (k < 3) span = 0;
    foreach (c[i]) c[i] = pick_coord(span);
    if (k == 19) begin
      // parallel or collinear copy of segment a
      c[4] = c[0] + pick_coord(3); c[5] = c[1] + pick_coord(3);
      c[6] = c[4] + (c[2] - c[0]); c[7] = c[5] + (c[3] - c[1]);
    end
  endfunction

  task add_directed(int x0, int y0, int x1, int y1, int u0, int v0, int u1, int v1);
    coord_t c[8];
    c = '{coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1),
          coord_t'(u0), coord_t'(v0), coord_t'(u1), coord_t'(v1)};
    directed.push_back(c);
  endtask

  initial begin
    coord_t c[8];
    repeat (11) @(posedge clk);
    rst <= 0;
    add_directed(0, 0, 10, 10, 0, 10, 10, 0);
    add_directed(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    add_directed(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
    add_directed(0, 0, 10, 0, 0, 5, 10, 5);
    add_directed(0, 0, 10, 0, 2, 0, 20, 0);
    add_directed(0, 0, 10, 0, 10, 0, 10, 10);
    add_directed(0, 0, 10, 0, 0, 0, 0, -7);
    add_directed(0, 0, 10, 0, 11, -1, 11, 1);
    add_directed(5, 5, 5, 5, 0, 0, 10, 10);
    add_directed(0, 0, 0, 0, 0, 0, 0, 0);
    add_directed(0, 0, 3, 1, 1, -1, 2, 2);
    add_directed(-7, 3, 9, -4, 2, -9, -1, 8);
    add_directed(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
    add_directed(32767, 32767, -32768, -32767, -1, 32767, 0, -32768);
    add_directed(0, 0, 1, 0, 0, 0, 0, 1);
    add_directed(-1, -1, -1, -1, -1, -1, -1, -1);
    add_directed(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
    add_directed(1, 2, -3, -5, 1, 2, 4, 9);
    add_directed(10, 0, 0, 10, 0, 0, 10, 10);
    foreach (directed[i]) send_pair(directed[i]);
    repeat (NUM_RANDOM) begin
      random_pair(c);
      send_pair(c);
    end
    src_valid <= 0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) sb.check_result(hit, point_x, point_y);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!pressure_done && pairs_sent >= 400) begin
        res_stall <= 1;
        stall_left = 300;
        pressure_done = 1;
      end else if (pairs_sent < QUIET_FROM && $urandom_range(0, 7) == 0) begin
        res_stall <= 1;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        res_stall <= 0;
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((src_valid && !src_stall) || (res_valid && !res_stall))
      idle_cycles = 0;
    else if (!rst)
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end
endmodule

>>> filelist.f
src/segi_pkg.sv
src/segi_div.sv
src/segment_intersection_top.sv
tb/segment_intersection_top_tb.sv
